>>> hdl/bal_pkg.sv
// ----------------------------------------------------------------------------
// bal_pkg: shared types and constants of the bounded array list
// Operation and status codes, sequencer states, modulo unit bundles.
// ----------------------------------------------------------------------------
package bal_pkg;

   localparam int unsigned OP_W    = 3;
   localparam int unsigned VAL_W   = 32;
   localparam int unsigned CNT_W   = 4;
   localparam int unsigned AMT_W   = 8;
   localparam int unsigned STAT_W  = 3;

   typedef enum logic [OP_W-1:0] {
      OP_INS_FRONT = 3'd0,
      OP_INS_BACK  = 3'd1,
      OP_INS_POS   = 3'd2,
      OP_DEL_FRONT = 3'd3,
      OP_DEL_BACK  = 3'd4,
      OP_DEL_POS   = 3'd5,
      OP_SEARCH    = 3'd6,
      OP_ROTATE    = 3'd7
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK        = 3'd0,
      ST_FULL      = 3'd1,
      ST_EMPTY     = 3'd2,
      ST_BAD_POS   = 3'd3,
      ST_NOT_FOUND = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MOD,
      S_ROT_RD,
      S_ROT_GET,
      S_UP,
      S_FIN_WR,
      S_DEL_RD,
      S_DOWN,
      S_WAIT,
      S_SRCH,
      S_DONE
   } seq_state_type;

   typedef struct packed {
      logic             start;
      logic [AMT_W-1:0] dividend;
      logic [CNT_W-1:0] divisor;
   } mod_req_type;

   typedef struct packed {
      logic             done;
      logic [CNT_W-1:0] remainder;
   } mod_rsp_type;

endpackage

>>> hdl/bal_if.sv
// ----------------------------------------------------------------------------
// bal_req_if / bal_rsp_if: request and response channels
// Valid/ready channels carrying one list operation and its result.
// ----------------------------------------------------------------------------
interface bal_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [bal_pkg::OP_W-1:0]             op;
   logic signed [bal_pkg::VAL_W-1:0]     value;
   logic [bal_pkg::CNT_W-1:0]            position;
   logic [bal_pkg::AMT_W-1:0]            rotate_amount;

   modport source (output valid, output op, output value, output position,
                   output rotate_amount, input ready);
   modport sink (input valid, input op, input value, input position,
                 input rotate_amount, output ready);
endinterface

interface bal_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [bal_pkg::STAT_W-1:0]           status;
   logic signed [bal_pkg::VAL_W-1:0]     removed_value;
   logic [bal_pkg::CNT_W-1:0]            found_position;
   logic [bal_pkg::CNT_W-1:0]            entry_count;

   modport source (output valid, output status, output removed_value,
                   output found_position, output entry_count, input ready);
   modport sink (input valid, input status, input removed_value,
                 input found_position, input entry_count, output ready);
endinterface

>>> hdl/bal_mod.sv
// ----------------------------------------------------------------------------
// bal_mod: bit-serial remainder unit
// Reduces the rotate amount modulo the entry count, one bit per cycle.
// ----------------------------------------------------------------------------
module bal_mod (
   input  logic                 clock,
   input  logic                 reset,
   input  bal_pkg::mod_req_type mod_req,
   output bal_pkg::mod_rsp_type mod_rsp
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [2:0]                    idx_ff, idx_in;
   logic [bal_pkg::AMT_W-1:0]     sh_ff, sh_in;
   logic [bal_pkg::CNT_W-1:0]     rem_ff, rem_in;
   logic [bal_pkg::CNT_W-1:0]     div_ff, div_in;
   logic [bal_pkg::CNT_W:0]       trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      idx_in  = idx_ff;
      sh_in   = sh_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      trial   = {rem_ff, sh_ff[bal_pkg::AMT_W-1]};
      if (mod_req.start) begin
         busy_in = 1'b1;
         idx_in  = 3'd7;
         sh_in   = mod_req.dividend;
         rem_in  = '0;
         div_in  = mod_req.divisor;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract once if it fits
         if (trial >= {1'b0, div_ff}) begin
            rem_in = bal_pkg::CNT_W'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[bal_pkg::CNT_W-1:0];
         end
         sh_in = {sh_ff[bal_pkg::AMT_W-2:0], 1'b0};
         if (idx_ff == 3'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            idx_in = idx_ff - 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      idx_ff <= idx_in;
      sh_ff  <= sh_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign mod_rsp.done      = done_ff;
   assign mod_rsp.remainder = rem_ff;

endmodule

>>> hdl/bounded_array_list.sv
// ----------------------------------------------------------------------------
// bounded_array_list: ordered list of up to DEPTH signed words
// Insert, delete, search and rotate over an entry memory with one read and one write port.
// ----------------------------------------------------------------------------
// Flow: full, empty, bad position or a rotate of an empty list touch no memory;
//   an insert moves each entry from the target on up one place (none when it
//   appends), a delete each entry after it down; a search reads to the match or
//   the count; a rotate moves the last entry first, amount mod count times.
// Throughput: one transaction at a time; a new request is taken while a finished
//   response still waits. Reset: synchronous; clears count, sequencer, valid.
module bounded_array_list #(
   parameter int unsigned DEPTH = 8
) (
   input  logic     clock,
   input  logic     reset,
   bal_req_if.sink  req_if,
   bal_rsp_if.source rsp_if
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [bal_pkg::CNT_W-1:0] FULL_CNT = bal_pkg::CNT_W'(DEPTH);

   // entry memory: one write and one registered read per cycle
   logic [bal_pkg::VAL_W-1:0] entries [DEPTH];

   logic                       mem_re;
   logic [AW-1:0]              mem_raddr;
   logic                       mem_we;
   logic [AW-1:0]              mem_waddr;
   logic [bal_pkg::VAL_W-1:0]  mem_wdata;
   logic [bal_pkg::VAL_W-1:0]  rdata_ff;

   // sequencer state and working registers
   bal_pkg::seq_state_type     state_ff, state_in;
   bal_pkg::op_type            op_ff, op_in;
   logic [bal_pkg::VAL_W-1:0]  value_ff, value_in;
   logic [bal_pkg::CNT_W-1:0]  fill_ff, fill_in;
   logic [bal_pkg::CNT_W-1:0]  ptr_ff, ptr_in;
   logic [bal_pkg::CNT_W-1:0]  lo_ff, lo_in;
   logic [bal_pkg::CNT_W-1:0]  hi_ff, hi_in;
   logic [bal_pkg::CNT_W-1:0]  k_ff, k_in;
   logic [bal_pkg::VAL_W-1:0]  fin_data_ff, fin_data_in;
   logic                       wpend_ff, wpend_in;
   logic [AW-1:0]              wpend_addr_ff, wpend_addr_in;
   logic                       cap_ff, cap_in;
   logic                       chk_ff, chk_in;
   logic [bal_pkg::CNT_W-1:0]  chk_idx_ff, chk_idx_in;
   bal_pkg::status_type        status_ff, status_in;
   logic [bal_pkg::VAL_W-1:0]  removed_ff, removed_in;
   logic [bal_pkg::CNT_W-1:0]  found_ff, found_in;

   // response register
   logic                       rsp_valid_ff, rsp_valid_in;
   bal_pkg::status_type        rsp_status_ff, rsp_status_in;
   logic [bal_pkg::VAL_W-1:0]  rsp_removed_ff, rsp_removed_in;
   logic [bal_pkg::CNT_W-1:0]  rsp_found_ff, rsp_found_in;
   logic [bal_pkg::CNT_W-1:0]  rsp_count_ff, rsp_count_in;

   logic                       req_fire;
   logic [bal_pkg::CNT_W:0]    pos_ext;
   logic [bal_pkg::CNT_W:0]    fill_ext;
   logic [bal_pkg::CNT_W-1:0]  at;

   bal_pkg::mod_req_type       mod_req;
   bal_pkg::mod_rsp_type       mod_rsp;

   bal_mod u_mod (
      .clock   (clock),
      .reset   (reset),
      .mod_req (mod_req),
      .mod_rsp (mod_rsp)
   );

   assign req_if.ready = (state_ff == bal_pkg::S_IDLE);
   assign req_fire     = req_if.valid && req_if.ready;
   assign pos_ext      = {1'b0, req_if.position};
   assign fill_ext     = {1'b0, fill_ff};

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      value_in      = value_ff;
      fill_in       = fill_ff;
      ptr_in        = ptr_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      k_in          = k_ff;
      fin_data_in   = fin_data_ff;
      wpend_in      = 1'b0;
      wpend_addr_in = wpend_addr_ff;
      cap_in        = 1'b0;
      chk_in        = 1'b0;
      chk_idx_in    = chk_idx_ff;
      status_in     = status_ff;
      removed_in    = removed_ff;
      found_in      = found_ff;
      at            = '0;

      mod_req.start    = 1'b0;
      mod_req.dividend = req_if.rotate_amount;
      mod_req.divisor  = fill_ff;

      // memory defaults: reads at the walking pointer, writes drain a move
      mem_re    = 1'b0;
      mem_raddr = ptr_ff[AW-1:0];
      mem_we    = wpend_ff;
      mem_waddr = wpend_addr_ff;
      mem_wdata = rdata_ff;

      // the delete target's word lands in rdata_ff the cycle after its read; keep it
      if (cap_ff) begin
         removed_in = rdata_ff;
      end

      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_removed_in = rsp_removed_ff;
      rsp_found_in   = rsp_found_ff;
      rsp_count_in   = rsp_count_ff;

      case (state_ff)
         bal_pkg::S_IDLE: begin
            if (req_fire) begin
               op_in      = bal_pkg::op_type'(req_if.op);
               value_in   = req_if.value;
               removed_in = '0;
               found_in   = '0;
               status_in  = bal_pkg::ST_OK;
               state_in   = bal_pkg::S_DONE;
               case (bal_pkg::op_type'(req_if.op))
                  bal_pkg::OP_INS_FRONT, bal_pkg::OP_INS_BACK,
                  bal_pkg::OP_INS_POS: begin
                     if (req_if.op == bal_pkg::OP_INS_FRONT) begin
                        at = '0;
                     end else if (req_if.op == bal_pkg::OP_INS_BACK) begin
                        at = fill_ff;
                     end else begin
                        at = req_if.position - 4'd1;
                     end
                     if (fill_ff == FULL_CNT) begin
                        status_in = bal_pkg::ST_FULL;
                     end else if (req_if.op == bal_pkg::OP_INS_POS &&
                                  (req_if.position == '0 || pos_ext > fill_ext + 5'd1)) begin
                        status_in = bal_pkg::ST_BAD_POS;
                     end else begin
                        // open a gap at the target, then drop the word in
                        fill_in     = fill_ff + 4'd1;
                        fin_data_in = req_if.value;
                        lo_in       = at;
                        ptr_in      = fill_ff - 4'd1;
                        state_in    = (at == fill_ff) ? bal_pkg::S_FIN_WR : bal_pkg::S_UP;
                     end
                  end
                  bal_pkg::OP_DEL_FRONT, bal_pkg::OP_DEL_BACK,
                  bal_pkg::OP_DEL_POS: begin
                     if (req_if.op == bal_pkg::OP_DEL_FRONT) begin
                        at = '0;
                     end else if (req_if.op == bal_pkg::OP_DEL_BACK) begin
                        at = fill_ff - 4'd1;
                     end else begin
                        at = req_if.position - 4'd1;
                     end
                     if (fill_ff == '0) begin
                        status_in = bal_pkg::ST_EMPTY;
                     end else if (req_if.op == bal_pkg::OP_DEL_POS &&
                                  (req_if.position == '0 || pos_ext > fill_ext)) begin
                        status_in = bal_pkg::ST_BAD_POS;
                     end else begin
                        // read the target, then close the gap upwards
                        fill_in  = fill_ff - 4'd1;
                        hi_in    = fill_ff - 4'd1;
                        ptr_in   = at;
                        state_in = bal_pkg::S_DEL_RD;
                     end
                  end
                  bal_pkg::OP_SEARCH: begin
                     status_in = bal_pkg::ST_NOT_FOUND;
                     hi_in     = fill_ff;
                     ptr_in    = '0;
                     state_in  = bal_pkg::S_SRCH;
                  end
                  bal_pkg::OP_ROTATE: begin
                     // an empty list stays as it is
                     if (fill_ff != '0) begin
                        mod_req.start = 1'b1;
                        hi_in         = fill_ff - 4'd1;
                        lo_in         = '0;
                        state_in      = bal_pkg::S_MOD;
                     end
                  end
                  default: begin
                     state_in = bal_pkg::S_DONE;
                  end
               endcase
            end
         end

         bal_pkg::S_MOD: begin
            if (mod_rsp.done) begin
               k_in     = mod_rsp.remainder;
               state_in = (mod_rsp.remainder == '0) ? bal_pkg::S_DONE : bal_pkg::S_ROT_RD;
            end
         end

         bal_pkg::S_ROT_RD: begin
            // fetch the last word, it wraps round to the front
            mem_re    = 1'b1;
            mem_raddr = hi_ff[AW-1:0];
            state_in  = bal_pkg::S_ROT_GET;
         end

         bal_pkg::S_ROT_GET: begin
            fin_data_in = rdata_ff;
            ptr_in      = hi_ff - 4'd1;
            state_in    = bal_pkg::S_UP;
         end

         bal_pkg::S_UP: begin
            // move each word one place up, walking down to the gap
            mem_re        = 1'b1;
            wpend_in      = 1'b1;
            wpend_addr_in = AW'(ptr_ff + 4'd1);
            if (ptr_ff == lo_ff) begin
               state_in = bal_pkg::S_FIN_WR;
            end else begin
               ptr_in = ptr_ff - 4'd1;
            end
         end

         bal_pkg::S_FIN_WR: begin
            // let the last move land first, then fill the gap
            if (!wpend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = lo_ff[AW-1:0];
               mem_wdata = fin_data_ff;
               state_in  = bal_pkg::S_DONE;
               if (op_ff == bal_pkg::OP_ROTATE) begin
                  k_in = k_ff - 4'd1;
                  if (k_ff != 4'd1) begin
                     state_in = bal_pkg::S_ROT_RD;
                  end
               end
            end
         end

         bal_pkg::S_DEL_RD: begin
            mem_re = 1'b1;
            cap_in = 1'b1;
            if (ptr_ff == hi_ff) begin
               state_in = bal_pkg::S_WAIT;
            end else begin
               ptr_in   = ptr_ff + 4'd1;
               state_in = bal_pkg::S_DOWN;
            end
         end

         bal_pkg::S_DOWN: begin
            // move each word one place down, walking up to the tail
            mem_re        = 1'b1;
            wpend_in      = 1'b1;
            wpend_addr_in = AW'(ptr_ff - 4'd1);
            if (ptr_ff == hi_ff) begin
               state_in = bal_pkg::S_WAIT;
            end else begin
               ptr_in = ptr_ff + 4'd1;
            end
         end

         bal_pkg::S_WAIT: begin
            state_in = bal_pkg::S_DONE;
         end

         bal_pkg::S_SRCH: begin
            // compare the word read last cycle while the next one is fetched
            if (chk_ff && rdata_ff == value_ff) begin
               status_in = bal_pkg::ST_OK;
               found_in  = chk_idx_ff + 4'd1;
               state_in  = bal_pkg::S_DONE;
            end else if (ptr_ff != hi_ff) begin
               mem_re     = 1'b1;
               chk_in     = 1'b1;
               chk_idx_in = ptr_ff;
               ptr_in     = ptr_ff + 4'd1;
            end else begin
               state_in = bal_pkg::S_DONE;
            end
         end

         bal_pkg::S_DONE: begin
            // hold until the response register is free
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_ff;
               rsp_removed_in = removed_ff;
               rsp_found_in   = found_ff;
               rsp_count_in   = fill_ff;
               state_in       = bal_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = bal_pkg::S_IDLE;
         end
      endcase
   end

   // entry memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entries[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= entries[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bal_pkg::S_IDLE;
         fill_ff      <= '0;
         wpend_ff     <= 1'b0;
         cap_ff       <= 1'b0;
         chk_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         wpend_ff     <= wpend_in;
         cap_ff       <= cap_in;
         chk_ff       <= chk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff          <= op_in;
      value_ff       <= value_in;
      ptr_ff         <= ptr_in;
      lo_ff          <= lo_in;
      hi_ff          <= hi_in;
      k_ff           <= k_in;
      fin_data_ff    <= fin_data_in;
      wpend_addr_ff  <= wpend_addr_in;
      chk_idx_ff     <= chk_idx_in;
      status_ff      <= status_in;
      removed_ff     <= removed_in;
      found_ff       <= found_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.status         = rsp_status_ff;
   assign rsp_if.removed_value  = rsp_removed_ff;
   assign rsp_if.found_position = rsp_found_ff;
   assign rsp_if.entry_count    = rsp_count_ff;

endmodule

>>> hdl/bal_checker.sv
// ----------------------------------------------------------------------------
// bal_checker: port-level checks of the bounded array list
// Response stability and consistency of result fields with the status.
// ----------------------------------------------------------------------------
module bal_checker #(
   parameter int unsigned DEPTH = 8
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [bal_pkg::STAT_W-1:0]    rsp_status,
   input logic [bal_pkg::VAL_W-1:0]     rsp_removed,
   input logic [bal_pkg::CNT_W-1:0]     rsp_found,
   input logic [bal_pkg::CNT_W-1:0]     rsp_count
);

   // a stalled transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_removed) && $stable(rsp_found) && $stable(rsp_count))
      else $error("response changed while stalled");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_count <= bal_pkg::CNT_W'(DEPTH))
      else $error("entry count beyond depth");

   a_removed_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_removed != '0 |-> rsp_status == bal_pkg::ST_OK)
      else $error("removed word on a failed transaction");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found != '0 |-> rsp_status == bal_pkg::ST_OK)
      else $error("found position on a failed transaction");

endmodule

bind bounded_array_list bal_checker #(.DEPTH(DEPTH)) u_bal_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .rsp_status  (rsp_if.status),
   .rsp_removed (rsp_if.removed_value),
   .rsp_found   (rsp_if.found_position),
   .rsp_count   (rsp_if.entry_count)
);

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the bounded array list
// Drives list operations through the request channel and checks every
// response field against a queue-based list predictor kept in the bench.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int unsigned LIST_DEPTH   = 8;
   // Cycles without any accepted transaction before the run is abandoned.
   // The slowest correct stretch is the long response hold-off plus a
   // worst-case rotate; allow several times that.
   localparam int unsigned STALL_LIMIT  = 3000;
   localparam int unsigned HOLD_CYCLES  = 400;
   // Settling time after the last response, well above the longest rotate.
   localparam int unsigned DRAIN_CYCLES = 200;

   // One predicted response, at the widths of the response channel.
   typedef struct packed {
      bal_pkg::status_type                status;
      logic signed [bal_pkg::VAL_W-1:0]   removed_value;
      logic [bal_pkg::CNT_W-1:0]          found_position;
      logic [bal_pkg::CNT_W-1:0]          entry_count;
   } list_result_type;

   logic clock;
   logic reset;

   bal_req_if req_if ();
   bal_rsp_if rsp_if ();

   bounded_array_list #(
      .DEPTH (LIST_DEPTH)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // Shadow copy of the list contents, front of the list at index 0.
   logic signed [bal_pkg::VAL_W-1:0] shadow_list[$];
   // Responses predicted for accepted requests, oldest first.
   list_result_type                  expected_responses[$];

   int unsigned mismatch_count = 0;
   // Percentages of cycles in which the request side and the response side idle.
   int unsigned req_gap_pct    = 0;
   int unsigned rsp_stall_pct  = 0;
   // Requested response hold-off; the response process counts it down.
   int unsigned rsp_hold_cycles = 0;

   // -------------------------------------------------------------------------
   // Clock: 10 ns period.
   // -------------------------------------------------------------------------
   initial clock = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // List predictor: apply one operation to the shadow list and return the
   // response it should produce. Full and empty take precedence over the
   // position check; rotating an empty list leaves it alone and reports ok.
   // -------------------------------------------------------------------------
   function automatic list_result_type apply_list_op(
      bal_pkg::op_type                  op,
      logic signed [bal_pkg::VAL_W-1:0] value,
      logic [bal_pkg::CNT_W-1:0]        position,
      logic [bal_pkg::AMT_W-1:0]        amount
   );
      list_result_type result;
      int              slot;
      int unsigned     steps;

      result.status         = bal_pkg::ST_OK;
      result.removed_value  = '0;
      result.found_position = '0;

      case (op)
         bal_pkg::OP_INS_FRONT, bal_pkg::OP_INS_BACK, bal_pkg::OP_INS_POS: begin
            if (shadow_list.size() >= LIST_DEPTH) begin
               result.status = bal_pkg::ST_FULL;
            end else if (op == bal_pkg::OP_INS_POS &&
                         (position == 0 || position > shadow_list.size() + 1)) begin
               result.status = bal_pkg::ST_BAD_POS;
            end else begin
               if (op == bal_pkg::OP_INS_FRONT)
                  slot = 0;
               else if (op == bal_pkg::OP_INS_BACK)
                  slot = shadow_list.size();
               else
                  slot = int'(position) - 1;
               shadow_list.insert(slot, value);
            end
         end
         bal_pkg::OP_DEL_FRONT, bal_pkg::OP_DEL_BACK, bal_pkg::OP_DEL_POS: begin
            if (shadow_list.size() == 0) begin
               result.status = bal_pkg::ST_EMPTY;
            end else if (op == bal_pkg::OP_DEL_POS &&
                         (position == 0 || position > shadow_list.size())) begin
               result.status = bal_pkg::ST_BAD_POS;
            end else begin
               if (op == bal_pkg::OP_DEL_FRONT)
                  slot = 0;
               else if (op == bal_pkg::OP_DEL_BACK)
                  slot = shadow_list.size() - 1;
               else
                  slot = int'(position) - 1;
               result.removed_value = shadow_list[slot];
               shadow_list.delete(slot);
            end
         end
         bal_pkg::OP_SEARCH: begin
            // First match wins; no match (or an empty list) is not found.
            result.status = bal_pkg::ST_NOT_FOUND;
            for (int i = 0; i < shadow_list.size() &&
                 result.status == bal_pkg::ST_NOT_FOUND; i++) begin
               if (shadow_list[i] == value) begin
                  result.status         = bal_pkg::ST_OK;
                  result.found_position = bal_pkg::CNT_W'(i + 1);
               end
            end
         end
         default: begin
            // Rotate right: the back entry moves to the front, amount mod count times.
            if (shadow_list.size() != 0) begin
               steps = amount % shadow_list.size();
               repeat (steps) shadow_list.push_front(shadow_list.pop_back());
            end
         end
      endcase

      result.entry_count = bal_pkg::CNT_W'(shadow_list.size());
      return result;
   endfunction

   // -------------------------------------------------------------------------
   // Request driver: idle at random, offer one transaction and hold it until
   // the block takes it. Valid stays high after acceptance so that back-to-back
   // transactions never drop it; the next idle cycle or the end of the test
   // lowers it.
   // -------------------------------------------------------------------------
   task automatic send_op(
      bal_pkg::op_type                  op,
      logic signed [bal_pkg::VAL_W-1:0] value,
      logic [bal_pkg::CNT_W-1:0]        position,
      logic [bal_pkg::AMT_W-1:0]        amount
   );
      while ($urandom_range(99) < req_gap_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.op            <= op;
      req_if.value         <= value;
      req_if.position      <= position;
      req_if.rotate_amount <= amount;
      do @(posedge clock); while (!req_if.ready);
      // Accepted at this edge: advance the predictor and queue its response.
      expected_responses.push_back(apply_list_op(op, value, position, amount));
   endtask

   // Word to insert or look for: often a small value so that duplicates and
   // repeated searches occur, sometimes an extreme, otherwise any word.
   function automatic logic signed [bal_pkg::VAL_W-1:0] pick_value();
      int unsigned roll;

      roll = $urandom_range(99);
      if (roll < 25)
         return $urandom_range(3);
      if (roll < 35) begin
         case ($urandom_range(3))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return -32'sd1;
            default: return 32'sd0;
         endcase
      end
      return $urandom;
   endfunction

   // -------------------------------------------------------------------------
   // Response side: check each accepted transaction against the oldest
   // prediction, then decide ready for the next cycle (hold-off first, then
   // random stalls).
   // -------------------------------------------------------------------------
   initial begin : response_sink
      list_result_type want;

      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            if (expected_responses.size() == 0) begin
               $error("response with none outstanding: status %0d count %0d",
                      rsp_if.status, rsp_if.entry_count);
               mismatch_count++;
            end else begin
               want = expected_responses.pop_front();
               if (rsp_if.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_if.status);
                  mismatch_count++;
               end
               if (rsp_if.removed_value !== want.removed_value) begin
                  $error("removed_value: expected %0d, got %0d",
                         want.removed_value, rsp_if.removed_value);
                  mismatch_count++;
               end
               if (rsp_if.found_position !== want.found_position) begin
                  $error("found_position: expected %0d, got %0d",
                         want.found_position, rsp_if.found_position);
                  mismatch_count++;
               end
               if (rsp_if.entry_count !== want.entry_count) begin
                  $error("entry_count: expected %0d, got %0d",
                         want.entry_count, rsp_if.entry_count);
                  mismatch_count++;
               end
            end
         end
         if (rsp_hold_cycles != 0) begin
            rsp_hold_cycles--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Watchdog: count cycles in which neither channel moves a transaction.
   // -------------------------------------------------------------------------
   initial begin : watchdog
      int unsigned quiet_cycles;

      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Directed: empty-list errors, bad positions either side of the valid
   // range, extreme words, fill to full, full-list errors, searches with and
   // without a match, rotates that wrap, then deletes from each end.
   // -------------------------------------------------------------------------
   task automatic test_directed();
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      // Empty list: every delete reports empty, even with a bad position.
      send_op(bal_pkg::OP_DEL_FRONT, '0, '0, '0);
      send_op(bal_pkg::OP_DEL_BACK, '0, '0, '0);
      send_op(bal_pkg::OP_DEL_POS, '0, '0, '0);
      send_op(bal_pkg::OP_SEARCH, '0, '0, '0);
      send_op(bal_pkg::OP_ROTATE, '0, '0, 8'hff);
      // Positional insert outside 1..count+1.
      send_op(bal_pkg::OP_INS_POS, 32'sd1, 4'd0, '0);
      send_op(bal_pkg::OP_INS_POS, 32'sd1, 4'd2, '0);
      send_op(bal_pkg::OP_INS_POS, 32'sh8000_0000, 4'd1, '0);
      send_op(bal_pkg::OP_INS_FRONT, 32'sh7fff_ffff, '0, '0);
      send_op(bal_pkg::OP_INS_BACK, -32'sd1, '0, '0);
      // Position count + 1 appends at the back.
      send_op(bal_pkg::OP_INS_POS, 32'sd0, 4'd4, '0);
      send_op(bal_pkg::OP_INS_POS, 32'sd5, 4'd2, '0);
      send_op(bal_pkg::OP_INS_BACK, 32'sd6, '0, '0);
      send_op(bal_pkg::OP_INS_BACK, 32'sd7, '0, '0);
      send_op(bal_pkg::OP_INS_BACK, 32'sd5, '0, '0);
      // Full list: full wins over a bad position.
      send_op(bal_pkg::OP_INS_FRONT, 32'sd9, '0, '0);
      send_op(bal_pkg::OP_INS_POS, 32'sd9, 4'd0, '0);
      send_op(bal_pkg::OP_SEARCH, 32'sd5, '0, '0);
      send_op(bal_pkg::OP_SEARCH, 32'sd123, '0, '0);
      send_op(bal_pkg::OP_ROTATE, '0, '0, 8'hff);
      send_op(bal_pkg::OP_ROTATE, '0, '0, 8'd8);
      send_op(bal_pkg::OP_ROTATE, '0, '0, 8'd1);
      send_op(bal_pkg::OP_DEL_POS, '0, 4'd0, '0);
      send_op(bal_pkg::OP_DEL_POS, '0, 4'd15, '0);
      send_op(bal_pkg::OP_DEL_POS, '0, 4'd8, '0);
      send_op(bal_pkg::OP_DEL_FRONT, '0, '0, '0);
      send_op(bal_pkg::OP_DEL_BACK, '0, '0, '0);
   endtask

   // -------------------------------------------------------------------------
   // Back-pressure: hold the response side off for a long stretch while the
   // request side keeps offering, so the block fills and stalls its input.
   // -------------------------------------------------------------------------
   task automatic test_backpressure();
      req_gap_pct     = 0;
      rsp_stall_pct   = 0;
      rsp_hold_cycles = HOLD_CYCLES;
      for (int n = 0; n < 24; n++)
         send_op(n % 3 == 0 ? bal_pkg::OP_SEARCH : bal_pkg::OP_INS_BACK,
                 pick_value(), '0, '0);
   endtask

   // -------------------------------------------------------------------------
   // Random: the list swings between empty and full so that every fill level
   // is visited. Most positions and search values are meaningful for the
   // current contents; a share of ops, positions and values is pure noise.
   // -------------------------------------------------------------------------
   task automatic test_random(int unsigned count, int unsigned gap_pct,
                              int unsigned stall_pct);
      bit                               growing;
      int unsigned                      roll;
      int unsigned                      top;
      bal_pkg::op_type                  op;
      logic signed [bal_pkg::VAL_W-1:0] value;
      logic [bal_pkg::CNT_W-1:0]        position;
      logic [bal_pkg::AMT_W-1:0]        amount;

      req_gap_pct   = gap_pct;
      rsp_stall_pct = stall_pct;
      growing       = 1'b1;
      for (int n = 0; n < count; n++) begin
         if (shadow_list.size() >= LIST_DEPTH)
            growing = 1'b0;
         else if (shadow_list.size() == 0)
            growing = 1'b1;

         roll = $urandom_range(99);
         if (roll < 8)
            op = bal_pkg::op_type'($urandom_range(7));
         else if (roll < 60)
            op = growing ? bal_pkg::op_type'($urandom_range(2)) :
                           bal_pkg::op_type'($urandom_range(5, 3));
         else if (roll < 75)
            op = growing ? bal_pkg::op_type'($urandom_range(5, 3)) :
                           bal_pkg::op_type'($urandom_range(2));
         else if (roll < 90)
            op = bal_pkg::OP_SEARCH;
         else
            op = bal_pkg::OP_ROTATE;

         if (op == bal_pkg::OP_SEARCH && shadow_list.size() != 0 &&
             $urandom_range(99) < 60)
            value = shadow_list[$urandom_range(shadow_list.size() - 1)];
         else
            value = pick_value();

         top = (op == bal_pkg::OP_DEL_POS) ? shadow_list.size() : shadow_list.size() + 1;
         if (top != 0 && $urandom_range(99) < 80)
            position = bal_pkg::CNT_W'($urandom_range(top, 1));
         else
            position = bal_pkg::CNT_W'($urandom_range(15));

         amount = ($urandom_range(99) < 30) ? bal_pkg::AMT_W'($urandom_range(9)) :
                                              bal_pkg::AMT_W'($urandom_range(255));
         send_op(op, value, position, amount);
      end
   endtask

   // -------------------------------------------------------------------------
   // Sequence: reset, directed, back-pressure, three random phases, drain.
   // -------------------------------------------------------------------------
   initial begin : run
      reset                <= 1'b1;
      req_if.valid         <= 1'b0;
      req_if.op            <= bal_pkg::OP_INS_FRONT;
      req_if.value         <= '0;
      req_if.position      <= '0;
      req_if.rotate_amount <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_backpressure();
      test_random(500, 28, 85);
      test_random(500, 85, 28);
      test_random(500, 0, 0);

      // Drop valid, wait for every predicted response, then let the block settle.
      req_if.valid <= 1'b0;
      while (expected_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
